// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ewct_pkg.sv -----
package ewct_pkg;

  localparam int KEY_W = 64;
  localparam int WIN_W = 16;
  localparam int NOW_W = 40;
  localparam int CNT_W = 16;
  localparam int EXP_W = 48;
  localparam int CAP_W = 7;

  localparam int IN_DATA_W = 120;
  localparam int OUT_DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_UPD,
    ST_DIV,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
    logic [EXP_W-1:0] expiry;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [EXP_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- rtl/expiring_window_counter_table.sv -----
// a new or refused key is answered after the expiry and key sweep and the update state; a key
//   already present also passes through the two-stage remaining-seconds divider
// no new item is taken until the result of the last one is loaded to the output; the expiry and
//   key sweep reads every table entry once through the single memory read port
// reset: all entries invalid, occupancy zero, capacity limit 64; memory contents are not cleared
`include "assert_macros.svh"

module expiring_window_counter_table #(
  parameter int TABLE_DEPTH = 64,
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // key_hash[63:0], window_seconds[79:64], now_ms[119:80]
  input  logic [ewct_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // count[15:0], ttl_seconds[31:16]
  output logic [ewct_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // status[0]
  output logic [0:0]                        m_axis_tuser_o,
  input  logic                              cfg_we_i,
  input  logic [ewct_pkg::CAP_W-1:0]        cfg_wdata_i
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LCW = (CW > ewct_pkg::CAP_W) ? CW : ewct_pkg::CAP_W;
  localparam int TW = $clog2(TICKS_PER_SECOND + 1);
  localparam int PROD_W = ewct_pkg::WIN_W + TW;
  localparam int KW = ewct_pkg::KEY_W;
  localparam int WW = ewct_pkg::WIN_W;
  localparam int NW = ewct_pkg::NOW_W;
  localparam int EW = ewct_pkg::EXP_W;
  localparam int QW = ewct_pkg::CNT_W;

  ewct_pkg::state_e state_q, state_d;

  logic [CW-1:0]          issue_cnt_q;
  logic                   chk_vld_q;
  logic [AW-1:0]          chk_idx_q;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [CW-1:0]          live_q;
  logic [ewct_pkg::CAP_W-1:0] cap_q;

  logic [KW-1:0]          key_q;
  logic [WW-1:0]          win_q;
  logic [NW-1:0]          now_q;
  logic [PROD_W-1:0]      prod_q;

  logic                   hit_fnd_q;
  logic [AW-1:0]          hit_idx_q;
  logic [QW-1:0]          hit_cnt_q;
  logic [EW-1:0]          hit_exp_q;
  logic                   free_fnd_q;
  logic [AW-1:0]          free_idx_q;

  logic                   res_status_q;
  logic [QW-1:0]          res_count_q;
  logic [QW-1:0]          res_ttl_q;

  logic                   m_valid_q;
  logic                   m_status_q;
  logic [QW-1:0]          m_count_q;
  logic [QW-1:0]          m_ttl_q;

  logic                   in_acc;
  logic                   sweep_last;
  logic                   mem_re;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  ewct_pkg::entry_t       mem_wdata;
  ewct_pkg::entry_t       mem_rdata;
  ewct_pkg::div_req_t     div_req;
  ewct_pkg::div_rsp_t     div_rsp;
  logic                   out_load;

  logic                   e_valid;
  logic                   e_expired;
  logic                   e_live;
  logic                   take_hit;
  logic                   take_free;
  logic                   cap_reached;
  logic                   ins_ok;
  logic [QW-1:0]          cnt_inc;
  logic [EW-1:0]          new_exp;
  logic [WW-1:0]          win_in;

  ewct_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (issue_cnt_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  ewct_ttl_div #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready_o = (state_q == ewct_pkg::ST_IDLE);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign win_in = s_axis_tdata_i[KW +: WW];

  assign sweep_last = (issue_cnt_q == CW'(TABLE_DEPTH)) && chk_vld_q;

  // per-entry check on the word read in the previous cycle
  assign e_valid   = valid_q[chk_idx_q];
  assign e_expired = e_valid && (mem_rdata.expiry <= EW'(now_q));
  assign e_live    = e_valid && !e_expired;
  assign take_hit  = chk_vld_q && e_live && (mem_rdata.key == key_q) && !hit_fnd_q;
  assign take_free = chk_vld_q && !e_live && !free_fnd_q;

  assign cap_reached = LCW'(live_q) >= LCW'(cap_q);
  assign ins_ok      = !hit_fnd_q && free_fnd_q && !cap_reached;
  assign cnt_inc     = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + 1'b1;
  assign new_exp     = EW'(now_q) + EW'(prod_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ewct_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = ewct_pkg::ST_SWEEP;
        end
      end
      ewct_pkg::ST_SWEEP: begin
        if (sweep_last) begin
          state_d = ewct_pkg::ST_UPD;
        end
      end
      ewct_pkg::ST_UPD: begin
        state_d = hit_fnd_q ? ewct_pkg::ST_DIV : ewct_pkg::ST_RESP;
      end
      ewct_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ewct_pkg::ST_RESP;
        end
      end
      ewct_pkg::ST_RESP: begin
        if (out_load) begin
          state_d = ewct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ewct_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_re           = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = hit_idx_q;
    mem_wdata.key    = key_q;
    mem_wdata.count  = cnt_inc;
    mem_wdata.expiry = hit_exp_q;
    div_req.start    = 1'b0;
    div_req.dividend = hit_exp_q - EW'(now_q);
    out_load         = 1'b0;
    case (state_q)
      ewct_pkg::ST_SWEEP: begin
        mem_re = issue_cnt_q < CW'(TABLE_DEPTH);
      end
      ewct_pkg::ST_UPD: begin
        if (hit_fnd_q) begin
          mem_we        = 1'b1;
          div_req.start = 1'b1;
        end else if (ins_ok) begin
          mem_we           = 1'b1;
          mem_waddr        = free_idx_q;
          mem_wdata.count  = QW'(1);
          mem_wdata.expiry = new_exp;
        end
      end
      ewct_pkg::ST_RESP: begin
        out_load = !m_valid_q || m_axis_tready_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ewct_pkg::ST_IDLE;
      issue_cnt_q <= '0;
      chk_vld_q   <= 1'b0;
      valid_q     <= '0;
      live_q      <= '0;
      cap_q       <= ewct_pkg::CAP_RESET;
      hit_fnd_q   <= 1'b0;
      free_fnd_q  <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        issue_cnt_q <= '0;
        chk_vld_q   <= 1'b0;
        hit_fnd_q   <= 1'b0;
        free_fnd_q  <= 1'b0;
      end
      if (state_q == ewct_pkg::ST_SWEEP) begin
        chk_vld_q <= mem_re;
        if (mem_re) begin
          issue_cnt_q <= issue_cnt_q + 1'b1;
        end
        if (chk_vld_q && e_expired) begin
          valid_q[chk_idx_q] <= 1'b0;
          if (live_q != '0) begin
            live_q <= live_q - 1'b1;
          end
        end
        if (take_hit) begin
          hit_fnd_q <= 1'b1;
        end
        if (take_free) begin
          free_fnd_q <= 1'b1;
        end
      end
      if (state_q == ewct_pkg::ST_UPD && ins_ok) begin
        valid_q[free_idx_q] <= 1'b1;
        live_q              <= live_q + 1'b1;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q <= s_axis_tdata_i[0 +: KW];
      win_q <= (win_in == '0) ? WW'(1) : win_in;
      now_q <= s_axis_tdata_i[KW + WW +: NW];
    end
    prod_q    <= PROD_W'(win_q) * PROD_W'(TICKS_PER_SECOND);
    chk_idx_q <= issue_cnt_q[AW-1:0];
    if (state_q == ewct_pkg::ST_SWEEP) begin
      if (take_hit) begin
        hit_idx_q <= chk_idx_q;
        hit_cnt_q <= mem_rdata.count;
        hit_exp_q <= mem_rdata.expiry;
      end
      if (take_free) begin
        free_idx_q <= chk_idx_q;
      end
    end
    if (state_q == ewct_pkg::ST_UPD) begin
      if (hit_fnd_q) begin
        res_status_q <= ewct_pkg::STATUS_OK;
        res_count_q  <= cnt_inc;
      end else if (ins_ok) begin
        res_status_q <= ewct_pkg::STATUS_OK;
        res_count_q  <= QW'(1);
        res_ttl_q    <= win_q;
      end else begin
        res_status_q <= ewct_pkg::STATUS_FULL;
        res_count_q  <= '0;
        res_ttl_q    <= '0;
      end
    end
    if (state_q == ewct_pkg::ST_DIV && div_rsp.done) begin
      res_ttl_q <= div_rsp.quot;
    end
    if (out_load) begin
      m_status_q <= res_status_q;
      m_count_q  <= res_count_q;
      m_ttl_q    <= res_ttl_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {m_ttl_q, m_count_q};
  assign m_axis_tuser_o  = m_status_q;

  `ASSERT_IMPL(a_live_matches_valid, 1'b1, $countones(valid_q) == int'(live_q),
               "occupancy count differs from number of valid entries")
  `ASSERT_IMPL(a_mem_write_in_update, mem_we, state_q == ewct_pkg::ST_UPD,
               "table write outside the update cycle")
  `ASSERT_IMPL(a_div_done_in_div, div_rsp.done, state_q == ewct_pkg::ST_DIV,
               "divider finished while not waiting for it")
  `ASSERT_NEXT(a_sweep_reads_all, state_q == ewct_pkg::ST_SWEEP && sweep_last,
               issue_cnt_q == CW'(TABLE_DEPTH) && !chk_vld_q,
               "sweep ended before every entry was checked")

endmodule

// ----- rtl/ewct_mem.sv -----
module ewct_mem #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  ewct_pkg::entry_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output ewct_pkg::entry_t rdata_o
);

  ewct_pkg::entry_t mem [DEPTH];
  ewct_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ewct_ttl_div.sv -----
module ewct_ttl_div #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ewct_pkg::div_req_t req_i,
  output ewct_pkg::div_rsp_t rsp_o
);

  localparam int DW = ewct_pkg::EXP_W;
  localparam int QW = ewct_pkg::CNT_W;
  localparam int LW = $clog2(TICKS_PER_SECOND);
  localparam int NW = LW + QW;
  localparam int MW = NW + 1;
  localparam int SH = NW + LW;
  localparam int PW = SH + QW;
  localparam logic [63:0] RECIP =
    ((64'd1 << SH) + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND);
  localparam logic [DW-1:0] SAT_LIM = DW'(TICKS_PER_SECOND) << QW;

  logic          stage_q;
  logic          done_q;
  logic [DW-1:0] rem_q;
  logic [PW-1:0] prod;
  logic [QW-1:0] quo_q;
  logic          sat_q;

  // exact below the saturation point, where the dividend fits in NW bits
  assign prod = PW'(rem_q[NW-1:0]) * PW'(RECIP[MW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= req_i.start;
      done_q  <= stage_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.dividend;
    end
    if (stage_q) begin
      sat_q <= rem_q >= SAT_LIM;
      quo_q <= prod[SH +: QW];
    end
  end

  always_comb begin
    rsp_o.done = done_q;
    if (sat_q) begin
      rsp_o.quot = '1;
    end else if (quo_q == '0) begin
      rsp_o.quot = QW'(1);
    end else begin
      rsp_o.quot = quo_q;
    end
  end

endmodule
